>>> hdl/tle_pkg.sv
// Shared types, codes and constants of the terminal line editor.
// Used by tle_esc, tle_mover and terminal_line_editor; depends on nothing.
package tle_pkg;

  localparam int unsigned LINE_DEPTH_DEF = 512;
  localparam int unsigned POS_W          = 9;
  localparam int unsigned CHAR_W         = 7;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [CHAR_W-1:0] char_t;

  // Opcodes of an input beat.
  localparam logic [1:0] OP_KEY  = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_NEW  = 2'd2;

  // Finish codes.
  localparam logic [2:0] FIN_EDIT  = 3'd0;
  localparam logic [2:0] FIN_ENTER = 3'd1;
  localparam logic [2:0] FIN_UP    = 3'd2;
  localparam logic [2:0] FIN_DOWN  = 3'd3;
  localparam logic [2:0] FIN_ABORT = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_MAX_LENGTH = 1'b0;
  localparam logic CFG_VIEW_WIDTH = 1'b1;

  localparam pos_t MAX_LENGTH_RST = 9'd255;
  localparam pos_t VIEW_WIDTH_RST = 9'd70;

  // Control bytes.
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_HOME    = 8'h01;
  localparam logic [7:0] CH_RIGHT   = 8'h04;
  localparam logic [7:0] CH_END     = 8'h06;
  localparam logic [7:0] CH_DEL     = 8'h07;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_RETURN  = 8'h0d;
  localparam logic [7:0] CH_LEFT    = 8'h13;
  localparam logic [7:0] CH_TRUNC   = 8'h14;
  localparam logic [7:0] CH_INS     = 8'h16;
  localparam logic [7:0] CH_CLEAR_X = 8'h18;
  localparam logic [7:0] CH_CLEAR_Y = 8'h19;
  localparam logic [7:0] CH_ESC     = 8'h1b;
  localparam logic [7:0] CH_PRINT_LO = 8'd32;
  localparam logic [7:0] CH_PRINT_HI = 8'd126;
  localparam logic [7:0] CH_RUBOUT  = 8'h7f;

  // Escape sequence bytes.
  localparam logic [7:0] CH_BRACKET = 8'h5b;
  localparam logic [7:0] CH_TILDE   = 8'h7e;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_KEY_A   = 8'h41;
  localparam logic [7:0] CH_KEY_B   = 8'h42;
  localparam logic [7:0] CH_KEY_C   = 8'h43;
  localparam logic [7:0] CH_KEY_D   = 8'h44;
  localparam logic [7:0] CH_KEY_F   = 8'h46;
  localparam logic [7:0] CH_KEY_H   = 8'h48;

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_OPEN,
    ESC_BODY,
    ESC_TILDE
  } esc_phase_t;

  typedef enum logic [3:0] {
    KEY_NONE,
    KEY_CHAR,
    KEY_UP,
    KEY_DOWN,
    KEY_RIGHT,
    KEY_LEFT,
    KEY_HOME,
    KEY_END,
    KEY_INS,
    KEY_DEL
  } key_kind_t;

  typedef struct packed {
    key_kind_t  kind;
    logic [7:0] code;
  } key_t;

  // Block move request: count reads starting at first, stepping down or up.
  typedef struct packed {
    logic go;
    logic down;
    pos_t first;
    pos_t count;
  } move_cmd_t;

  typedef struct packed {
    logic  we;
    pos_t  waddr;
    char_t wdata;
    pos_t  raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_PRE,
    S_EDIT,
    S_MOVE,
    S_WRITE,
    S_FIT,
    S_DONE
  } ctl_state_t;

endpackage

>>> hdl/tle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module tle_ram #(
  parameter int unsigned WIDTH = 7,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/tle_esc.sv
// Escape sequence decoder: turns raw terminal bytes into key codes.
// Depends on tle_pkg.
module tle_esc import tle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       clear,
  input  logic [7:0] key_byte,
  output key_t       key
);

  localparam logic [3:0] DIG_HOME = 4'd1;
  localparam logic [3:0] DIG_INS  = 4'd2;
  localparam logic [3:0] DIG_DEL  = 4'd3;
  localparam logic [3:0] DIG_END  = 4'd4;

  esc_phase_t phase, phase_next;
  logic       bracket, bracket_next;
  logic [3:0] digit, digit_next;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      phase   <= ESC_IDLE;
      bracket <= 1'b0;
      digit   <= '0;
    end else if (step) begin
      phase   <= phase_next;
      bracket <= bracket_next;
      digit   <= digit_next;
    end
  end

  always_comb begin
    phase_next   = phase;
    bracket_next = bracket;
    digit_next   = digit;
    key.kind     = KEY_NONE;
    key.code     = key_byte;
    case (phase)
      ESC_IDLE: begin
        if (key_byte == CH_ESC) begin
          phase_next = ESC_OPEN;
        end else begin
          key.kind = KEY_CHAR;
        end
      end
      ESC_OPEN: begin
        bracket_next = (key_byte == CH_BRACKET);
        phase_next   = ESC_BODY;
      end
      ESC_BODY: begin
        phase_next = ESC_IDLE;
        if (bracket) begin
          if (key_byte >= CH_DIGIT_0 && key_byte <= CH_DIGIT_9) begin
            digit_next = 4'(key_byte - CH_DIGIT_0);
            phase_next = ESC_TILDE;
          end else begin
            case (key_byte)
              CH_KEY_A: key.kind = KEY_UP;
              CH_KEY_B: key.kind = KEY_DOWN;
              CH_KEY_C: key.kind = KEY_RIGHT;
              CH_KEY_D: key.kind = KEY_LEFT;
              CH_KEY_H: key.kind = KEY_HOME;
              CH_KEY_F: key.kind = KEY_END;
              default:  key.kind = KEY_NONE;
            endcase
          end
        end
      end
      ESC_TILDE: begin
        phase_next = ESC_IDLE;
        if (key_byte == CH_TILDE) begin
          case (digit)
            DIG_HOME: key.kind = KEY_HOME;
            DIG_INS:  key.kind = KEY_INS;
            DIG_DEL:  key.kind = KEY_DEL;
            DIG_END:  key.kind = KEY_END;
            default:  key.kind = KEY_NONE;
          endcase
        end
      end
      default: phase_next = ESC_IDLE;
    endcase
  end

endmodule

>>> hdl/tle_mover.sv
// Block mover: shifts a run of line store entries by one place, one per cycle.
// Depends on tle_pkg; drives the RAM through a mem_req_t.
module tle_mover import tle_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  move_cmd_t cmd,
  input  char_t     rdata,
  output mem_req_t  req,
  output logic      busy
);

  pos_t remain;
  pos_t raddr;
  pos_t waddr;
  logic down;
  logic pend;

  // Read one entry a cycle; write it in the following cycle, one place up or down.
  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
      pend   <= 1'b0;
    end else if (cmd.go) begin
      remain <= cmd.count;
      pend   <= 1'b0;
    end else begin
      pend <= (remain != '0);
      if (remain != '0) begin
        remain <= remain - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      raddr <= cmd.first;
      down  <= cmd.down;
    end else if (remain != '0) begin
      raddr <= down ? raddr - 1'b1 : raddr + 1'b1;
      waddr <= down ? raddr + 1'b1 : raddr - 1'b1;
    end
  end

  assign req.we    = pend;
  assign req.waddr = waddr;
  assign req.wdata = rdata;
  assign req.raddr = raddr;
  assign busy      = (remain != '0) || pend;

endmodule

>>> hdl/terminal_line_editor.sv
// Top level of the terminal line editor: control sequencer and register file.
// Depends on tle_pkg, tle_esc, tle_mover and tle_ram.
//
//  channel   signals                                   direction  handshake
//  --------  ----------------------------------------  ---------  -------------------------
//  command   start, busy, opcode, key_byte, read_index  in         beat when start && !busy
//  result    done, read_char, line_length, cursor,      out        beat on done, one cycle
//            view_start, insert_on, finish
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  in         beat when valid && ready
//
// Insert, backspace and delete run the block mover over the line store,
// one entry per cycle, so such a key lasts longer the more entries it
// moves. The single RAM port pair and the mover's address stepper set
// that rate.
// rst is synchronous and active high; it clears the edit state and the
// escape decoder and loads the register defaults. The line store keeps no
// reset; entries at or beyond line_length read as zero. Results cannot stall:
// done is high for exactly one cycle per command beat.
module terminal_line_editor import tle_pkg::*; #(
  parameter int unsigned LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // command
  input  logic       start,
  output logic       busy,
  input  logic [1:0] opcode,
  input  logic [7:0] key_byte,
  input  logic [8:0] read_index,
  // result
  output logic       done,
  output logic [6:0] read_char,
  output logic [8:0] line_length,
  output logic [8:0] cursor,
  output logic [8:0] view_start,
  output logic       insert_on,
  output logic [2:0] finish,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int unsigned ADDR_W = $clog2(LINE_DEPTH);
  // Largest line the store can hold within the 9-bit register range.
  localparam int unsigned CAP    = (LINE_DEPTH > 511) ? 511 : LINE_DEPTH;
  localparam pos_t        CAP_POS = POS_W'(CAP);

  // Clip the cursor to the line limit.
  function automatic pos_t fit_cursor(input pos_t cur, input pos_t lim);
    fit_cursor = (cur > lim) ? lim : cur;
  endfunction

  // Keep the viewport start at or before the cursor and within the width.
  function automatic pos_t fit_view(input pos_t cur, input pos_t view, input pos_t width);
    pos_t v;
    v = (view > cur) ? cur : view;
    fit_view = ((cur - v) >= width) ? cur - width : v;
  endfunction

  ctl_state_t state, state_next;

  pos_t  max_length, view_width;
  pos_t  line_len, line_len_next;
  pos_t  cur_pos, cur_pos_next;
  pos_t  view_pos, view_pos_next;
  logic  ins_mode, ins_mode_next;
  logic [2:0] fin_code, fin_code_next;
  char_t rchar, rchar_next;
  logic  rd_ok, rd_ok_next;
  key_t  key, key_next;
  logic  do_write, do_write_next;
  pos_t  wpos, wpos_next;
  char_t wchar, wchar_next;

  logic      accept;
  logic      esc_step, esc_clear;
  key_t      esc_key;
  move_cmd_t mv_cmd;
  mem_req_t  mv_req;
  logic      mv_busy;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  char_t             ram_wdata, ram_rdata;

  pos_t lim;
  pos_t pre_cur;
  logic is_char;
  logic [7:0] c;
  pos_t top;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign done      = (state == S_DONE);
  assign cfg_ready = 1'b1;

  assign read_char   = rchar;
  assign line_length = line_len;
  assign cursor      = cur_pos;
  assign view_start  = view_pos;
  assign insert_on   = ins_mode;
  assign finish      = fin_code;

  // Effective line limit: max_length capped by what the store can hold.
  assign lim     = (max_length > CAP_POS) ? CAP_POS : max_length;
  assign pre_cur = fit_cursor(cur_pos, lim);
  assign is_char = (key.kind == KEY_CHAR);
  assign c       = key.code;

  tle_esc u_esc (
    .clk      (clk),
    .rst      (rst),
    .step     (esc_step),
    .clear    (esc_clear),
    .key_byte (key_byte),
    .key      (esc_key)
  );

  tle_mover u_mover (
    .clk   (clk),
    .rst   (rst),
    .cmd   (mv_cmd),
    .rdata (ram_rdata),
    .req   (mv_req),
    .busy  (mv_busy)
  );

  tle_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Hand the store to the mover while it runs; otherwise the sequencer
  // writes the typed character and reads at read_index.
  always_comb begin
    if (state == S_MOVE) begin
      ram_we    = mv_req.we;
      ram_waddr = ADDR_W'(mv_req.waddr);
      ram_wdata = mv_req.wdata;
      ram_raddr = ADDR_W'(mv_req.raddr);
    end else begin
      ram_we    = (state == S_WRITE);
      ram_waddr = ADDR_W'(wpos);
      ram_wdata = wchar;
      ram_raddr = ADDR_W'(read_index);
    end
  end

  // Configuration beats land at any time; the user must issue them only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RST;
      view_width <= VIEW_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_LENGTH: max_length <= cfg_data;
        CFG_VIEW_WIDTH: view_width <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      line_len <= '0;
      cur_pos  <= '0;
      view_pos <= '0;
      ins_mode <= 1'b1;
      fin_code <= FIN_EDIT;
      rchar    <= '0;
      do_write <= 1'b0;
    end else begin
      state    <= state_next;
      line_len <= line_len_next;
      cur_pos  <= cur_pos_next;
      view_pos <= view_pos_next;
      ins_mode <= ins_mode_next;
      fin_code <= fin_code_next;
      rchar    <= rchar_next;
      do_write <= do_write_next;
    end
  end

  // Payload registers of the current command.
  always_ff @(posedge clk) begin
    rd_ok <= rd_ok_next;
    key   <= key_next;
    wpos  <= wpos_next;
    wchar <= wchar_next;
  end

  always_comb begin
    state_next    = state;
    line_len_next = line_len;
    cur_pos_next  = cur_pos;
    view_pos_next = view_pos;
    ins_mode_next = ins_mode;
    fin_code_next = fin_code;
    rchar_next    = rchar;
    rd_ok_next    = rd_ok;
    key_next      = key;
    do_write_next = do_write;
    wpos_next     = wpos;
    wchar_next    = wchar;
    esc_step      = 1'b0;
    esc_clear     = 1'b0;
    mv_cmd        = '0;
    top           = line_len;

    case (state)
      S_IDLE: begin
        if (accept) begin
          rchar_next = '0;
          case (opcode)
            OP_KEY: begin
              // Drop key bytes once the line has ended.
              if (fin_code == FIN_EDIT) begin
                esc_step   = 1'b1;
                key_next   = esc_key;
                state_next = (esc_key.kind != KEY_NONE) ? S_PRE : S_DONE;
              end else begin
                state_next = S_DONE;
              end
            end
            OP_READ: begin
              rd_ok_next = (read_index < line_len);
              state_next = S_READ;
            end
            OP_NEW: begin
              line_len_next = '0;
              cur_pos_next  = '0;
              view_pos_next = '0;
              ins_mode_next = 1'b1;
              fin_code_next = FIN_EDIT;
              esc_clear     = 1'b1;
              state_next    = S_DONE;
            end
            default: state_next = S_DONE;
          endcase
        end
      end

      S_READ: begin
        rchar_next = rd_ok ? ram_rdata : '0;
        state_next = S_DONE;
      end

      S_PRE, S_FIT: begin
        cur_pos_next  = pre_cur;
        view_pos_next = fit_view(pre_cur, view_pos, view_width);
        state_next    = (state == S_PRE) ? S_EDIT : S_DONE;
      end

      S_EDIT: begin
        do_write_next = 1'b0;
        state_next    = S_MOVE;
        if (key.kind == KEY_HOME || (is_char && c == CH_HOME)) begin
          cur_pos_next  = '0;
          view_pos_next = '0;
        end else if (key.kind == KEY_END || (is_char && c == CH_END)) begin
          cur_pos_next = line_len;
          if (line_len > view_width) begin
            view_pos_next = line_len - view_width;
          end
        end else if (key.kind == KEY_INS || (is_char && c == CH_INS)) begin
          ins_mode_next = !ins_mode;
        end else if (key.kind == KEY_LEFT || (is_char && c == CH_LEFT)) begin
          if (cur_pos != '0) begin
            cur_pos_next = cur_pos - 1'b1;
          end
        end else if (key.kind == KEY_RIGHT || (is_char && c == CH_RIGHT)) begin
          if (cur_pos < line_len) begin
            cur_pos_next = cur_pos + 1'b1;
          end
        end else if (is_char && (c == CH_RUBOUT || c == CH_BS)) begin
          // Backspace: pull the tail down over the entry left of the cursor.
          if (cur_pos != '0 && line_len != '0) begin
            mv_cmd.go    = 1'b1;
            mv_cmd.down  = 1'b0;
            mv_cmd.first = cur_pos;
            mv_cmd.count = (cur_pos < line_len) ? line_len - cur_pos : '0;
            cur_pos_next  = cur_pos - 1'b1;
            line_len_next = line_len - 1'b1;
          end
        end else if (key.kind == KEY_DEL || (is_char && c == CH_DEL)) begin
          // Delete: pull the tail down over the entry under the cursor.
          if (cur_pos < line_len) begin
            mv_cmd.go     = 1'b1;
            mv_cmd.down   = 1'b0;
            mv_cmd.first  = cur_pos + 1'b1;
            mv_cmd.count  = line_len - cur_pos - 1'b1;
            line_len_next = line_len - 1'b1;
          end
        end else if (is_char && (c == CH_CLEAR_X || c == CH_CLEAR_Y)) begin
          line_len_next = '0;
          cur_pos_next  = '0;
          view_pos_next = '0;
        end else if (is_char && c == CH_TRUNC) begin
          line_len_next = cur_pos;
        end else if (key.kind == KEY_UP) begin
          fin_code_next = FIN_UP;
        end else if (key.kind == KEY_DOWN) begin
          fin_code_next = FIN_DOWN;
        end else if (is_char && c == CH_RETURN) begin
          fin_code_next = FIN_ENTER;
        end else if (is_char && c == CH_NUL) begin
          fin_code_next = FIN_ABORT;
        end else if (is_char && c >= CH_PRINT_LO && c <= CH_PRINT_HI && cur_pos < lim) begin
          if (ins_mode) begin
            // Open a gap at the cursor; a full line drops its last entry.
            if (line_len >= lim) begin
              top = lim - 1'b1;
            end else begin
              top           = line_len;
              line_len_next = line_len + 1'b1;
            end
            if (top > cur_pos) begin
              mv_cmd.go    = 1'b1;
              mv_cmd.down  = 1'b1;
              mv_cmd.first = top - 1'b1;
              mv_cmd.count = top - cur_pos;
            end
          end else if (cur_pos >= line_len) begin
            line_len_next = line_len + 1'b1;
          end
          do_write_next = 1'b1;
          wpos_next     = cur_pos;
          wchar_next    = c[CHAR_W-1:0];
          cur_pos_next  = cur_pos + 1'b1;
        end
      end

      S_MOVE: begin
        if (!mv_busy) begin
          state_next = do_write ? S_WRITE : S_FIT;
        end
      end

      S_WRITE: state_next = S_FIT;

      S_DONE: state_next = S_IDLE;

      default: state_next = S_IDLE;
    endcase
  end

endmodule
